FILE: hdl/akf_pkg.sv
// Shared types, codes and saturation helpers for the altitude Kalman filter.
// No dependencies; imported by akf_muldiv, altitude_kalman_filter, akf_checker and the testbench top.
package akf_pkg;

  localparam logic signed [63:0] COV_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] COV_MIN64 = -64'sh0000_8000_0000_0000;
  localparam logic signed [63:0] S32_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN   = -64'sh0000_0000_8000_0000;

  localparam logic [1:0] MODE_PREDICT = 2'd0;
  localparam logic [1:0] MODE_UPDATE  = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [2:0] REG_TIME_STEP = 3'd0;
  localparam logic [2:0] REG_MEAS_VAR  = 3'd1;
  localparam logic [2:0] REG_PROC_HH   = 3'd2;
  localparam logic [2:0] REG_PROC_HV   = 3'd3;
  localparam logic [2:0] REG_PROC_VV   = 3'd4;
  localparam logic [2:0] REG_ACC_OFF   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE_ADT,
    ST_PRE_P1,
    ST_PRE_P2,
    ST_PRE_T1,
    ST_PRE_T2,
    ST_PRE_T3,
    ST_UPD_DV,
    ST_UPD_VV,
    ST_UPD_HV,
    ST_UPD_DH,
    ST_UPD_HH,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_FIN
  } md_state_e;

  function automatic logic signed [63:0] ext32(input logic [31:0] x);
    return $signed({{32{x[31]}}, x});
  endfunction

  function automatic logic signed [63:0] ext48(input logic [47:0] x);
    return $signed({{16{x[47]}}, x});
  endfunction

  function automatic logic signed [63:0] ext50(input logic [49:0] x);
    return $signed({{14{x[49]}}, x});
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > S32_MAX) r = 32'h7FFF_FFFF;
    else if (x < S32_MIN) r = 32'h8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  // lo_zero: clamp to [0, max], else to the full signed 48-bit range
  function automatic logic [47:0] clamp_cov(input logic signed [63:0] x,
                                            input logic lo_zero);
    logic [47:0] r;
    if (x > COV_MAX64) r = COV_MAX64[47:0];
    else if (lo_zero && x < 64'sd0) r = 48'd0;
    else if (x < COV_MIN64) r = COV_MIN64[47:0];
    else r = x[47:0];
    return r;
  endfunction

endpackage

FILE: hdl/akf_dtmul.sv
// Bit-serial signed multiply by the unsigned 16-bit time step, one dt bit
// per cycle, with a final round-and-shift by 16 or 17. No package needed.
module akf_dtmul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [49:0] x_i,
  input  logic [15:0]        dt_i,
  input  logic               shift17_i,
  output logic               done_o,
  output logic signed [49:0] res_o
);

  logic signed [66:0] acc_q;
  logic signed [49:0] x_q;
  logic [15:0]        dt_q;
  logic [4:0]         cnt_q;
  logic               busy_q, done_q, sh_q;
  logic signed [49:0] res_q;
  logic signed [66:0] acc_step, acc_rnd;

  assign acc_step = (acc_q <<< 1) + (dt_q[15] ? $signed({{17{x_q[49]}}, x_q}) : 67'sd0);
  assign acc_rnd  = sh_q ? ((acc_q + 67'sd65536) >>> 17) : ((acc_q + 67'sd32768) >>> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd16;
      end else if (busy_q) begin
        if (cnt_q != 5'd0) begin
          cnt_q <= cnt_q - 5'd1;
        end else begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      x_q   <= x_i;
      dt_q  <= dt_i;
      sh_q  <= shift17_i;
    end else if (busy_q) begin
      if (cnt_q != 5'd0) begin
        acc_q <= acc_step;
        dt_q  <= {dt_q[14:0], 1'b0};
      end else begin
        res_q <= acc_rnd[49:0];
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: hdl/akf_muldiv.sv
// Serial round(a*b/c): shift-add multiply one bit a cycle, then restoring
// division one quotient bit a cycle; result capped at 2^62. Uses akf_pkg.
module akf_muldiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] a_i,
  input  logic [47:0] b_i,
  input  logic [47:0] c_i,
  output logic        done_o,
  output logic [62:0] q_o
);
  import akf_pkg::*;

  md_state_e   state_q, state_d;
  logic [6:0]  cnt_q;
  logic [95:0] prod_q;
  logic [47:0] rem_q, a_q, b_q, c_q;
  logic        done_q;
  logic [62:0] q_q;
  logic [48:0] rem_sh;
  logic        ge;
  logic        inc;
  logic [95:0] q_rnd;

  assign rem_sh = {rem_q, prod_q[95]};
  assign ge     = rem_sh >= {1'b0, c_q};
  assign inc    = rem_q >= (c_q - rem_q);
  assign q_rnd  = prod_q + {95'd0, inc};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MD_IDLE: if (start_i) state_d = MD_MUL;
      MD_MUL:  if (cnt_q == 7'd0) state_d = MD_DIV;
      MD_DIV:  if (cnt_q == 7'd0) state_d = MD_FIN;
      MD_FIN:  state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == MD_FIN);
      if (state_q == MD_IDLE) cnt_q <= 7'd47;
      else if (state_q == MD_MUL && cnt_q == 7'd0) cnt_q <= 7'd95;
      else if (cnt_q != 7'd0) cnt_q <= cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          a_q    <= a_i;
          b_q    <= b_i;
          c_q    <= c_i;
          prod_q <= '0;
          rem_q  <= '0;
        end
      end
      MD_MUL: begin
        prod_q <= {prod_q[94:0], 1'b0} + (b_q[47] ? {48'd0, a_q} : 96'd0);
        b_q    <= {b_q[46:0], 1'b0};
      end
      MD_DIV: begin
        // quotient bits shift in where dividend bits leave
        rem_q  <= ge ? 48'(rem_sh - {1'b0, c_q}) : rem_sh[47:0];
        prod_q <= {prod_q[94:0], ge};
      end
      MD_FIN: begin
        q_q <= (q_rnd > {33'd0, 63'h4000_0000_0000_0000}) ? 63'h4000_0000_0000_0000
                                                           : q_rnd[62:0];
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

FILE: hdl/altitude_kalman_filter.sv
// Top level of the two-state altitude Kalman filter with APB register port.
// Depends on akf_pkg, akf_dtmul and akf_muldiv.
//
//  channel  | signals                                   | direction
//  input    | in_valid_i, in_stall_o, mode_i, sample_*  | item in
//  output   | out_valid_o, out_stall_i, est_*, ...      | result out
//  config   | psel, penable, pwrite, paddr, pwdata ...  | 64-bit registers at 8*i
//
// Predict: six serial dt multiplies, run one after another.
// Update: five serial mul/div passes, each a multiply followed by a division.
// Restart, unused modes and updates with zero innovation variance skip the arithmetic units. One item at a time.
// Reset loads the register defaults and the initial state; no clearing pass.
// The next item is taken while a finished result waits in the output register.
module altitude_kalman_filter #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] sample_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] est_height_o,
  output logic [31:0] est_velocity_o,
  output logic [46:0] height_var_o,
  output logic        zero_innovation_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import akf_pkg::*;

  localparam logic [63:0] GRAVITY_FX = ((64'd981 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] HH_RAW = 64'd1 << (2 * FRAC_BITS - 1);
  localparam logic [63:0] VV_RAW = ((64'd105 << (2 * FRAC_BITS)) + 64'd50) / 64'd100;
  localparam logic [47:0] HH_INIT = (HH_RAW > 64'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF
                                                                   : HH_RAW[47:0];
  localparam logic [47:0] VV_INIT = (VV_RAW > 64'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF
                                                                   : VV_RAW[47:0];
  localparam logic [49:0] GRAV50 = GRAVITY_FX[49:0];

  // registers
  logic [15:0] time_step_q;
  logic [46:0] meas_var_q, proc_hh_q, proc_hv_q, proc_vv_q;
  logic [31:0] acc_off_q;

  // filter state
  logic [31:0] height_q, velocity_q;
  logic [47:0] cov_hh_q, cov_hv_q, cov_vv_q;

  state_e      state_q, state_d;
  logic        go_q, go_d;
  logic [31:0] sample_q;
  logic [32:0] y_q;
  logic [47:0] s_q;
  logic        flag_q;
  logic [49:0] adt_q, acc1_q, t2_q;

  logic        out_valid_q;
  logic [31:0] out_h_q, out_v_q;
  logic [46:0] out_var_q;
  logic        out_flag_q;

  logic        accept, cfg_wr, out_free;
  logic [47:0] s_now;
  logic [32:0] y_now;
  logic        pre_op, upd_op;
  logic signed [49:0] a_val, dm_x, dm_res;
  logic        dm_done, md_done;
  logic [47:0] md_a, md_b;
  logic        md_neg;
  logic [62:0] md_q;
  logic signed [63:0] md_m, dh64;
  logic [47:0] hv_mag, y_mag;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign s_now  = {1'b0, cov_hh_q[46:0]} + {1'b0, meas_var_q};
  assign y_now  = 33'($signed({sample_value_i[31], sample_value_i})
                    - $signed({height_q[31], height_q}));
  assign a_val  = $signed({{18{sample_q[31]}}, sample_q}) - $signed(GRAV50)
                  - $signed({{18{acc_off_q[31]}}, acc_off_q});
  assign hv_mag = cov_hv_q[47] ? 48'(-cov_hv_q) : cov_hv_q;
  assign y_mag  = y_q[32] ? 48'(-{{15{y_q[32]}}, y_q}) : {15'd0, y_q};

  assign pre_op = (state_q == ST_PRE_ADT) || (state_q == ST_PRE_P1) ||
                  (state_q == ST_PRE_P2) || (state_q == ST_PRE_T1) ||
                  (state_q == ST_PRE_T2) || (state_q == ST_PRE_T3);
  assign upd_op = (state_q == ST_UPD_DV) || (state_q == ST_UPD_VV) ||
                  (state_q == ST_UPD_HV) || (state_q == ST_UPD_DH) ||
                  (state_q == ST_UPD_HH);

  always_comb begin
    dm_x   = '0;
    md_a   = cov_hh_q;
    md_b   = {1'b0, meas_var_q};
    md_neg = 1'b0;
    unique case (state_q)
      ST_PRE_ADT: dm_x = a_val;
      ST_PRE_P1:  dm_x = $signed({{18{velocity_q[31]}}, velocity_q});
      ST_PRE_P2:  dm_x = adt_q;
      ST_PRE_T1:  dm_x = $signed({{2{cov_hv_q[47]}}, cov_hv_q});
      ST_PRE_T2:  dm_x = $signed({{2{cov_vv_q[47]}}, cov_vv_q});
      ST_PRE_T3:  dm_x = t2_q;
      ST_UPD_DV: begin
        md_a = hv_mag; md_b = y_mag; md_neg = cov_hv_q[47] ^ y_q[32];
      end
      ST_UPD_VV: begin
        md_a = hv_mag; md_b = hv_mag;
      end
      ST_UPD_HV: begin
        md_a = hv_mag; md_neg = cov_hv_q[47];
      end
      ST_UPD_DH: begin
        md_b = y_mag; md_neg = y_q[32];
      end
      default: ;
    endcase
  end

  akf_dtmul u_dtmul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (go_q && pre_op),
    .x_i       (dm_x),
    .dt_i      (time_step_q),
    .shift17_i (state_q == ST_PRE_P2),
    .done_o    (dm_done),
    .res_o     (dm_res)
  );

  akf_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q && upd_op),
    .a_i     (md_a),
    .b_i     (md_b),
    .c_i     (s_q),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  assign md_m = md_neg ? -$signed({1'b0, md_q}) : $signed({1'b0, md_q});
  assign dh64 = ext50(acc1_q) + ext50(dm_res);

  always_comb begin
    state_d = state_q;
    go_d    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_PREDICT) begin
            state_d = ST_PRE_ADT; go_d = 1'b1;
          end else if (mode_i == MODE_UPDATE && s_now != 48'd0) begin
            state_d = ST_UPD_DV; go_d = 1'b1;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_PRE_ADT: if (dm_done) begin state_d = ST_PRE_P1; go_d = 1'b1; end
      ST_PRE_P1:  if (dm_done) begin state_d = ST_PRE_P2; go_d = 1'b1; end
      ST_PRE_P2:  if (dm_done) begin state_d = ST_PRE_T1; go_d = 1'b1; end
      ST_PRE_T1:  if (dm_done) begin state_d = ST_PRE_T2; go_d = 1'b1; end
      ST_PRE_T2:  if (dm_done) begin state_d = ST_PRE_T3; go_d = 1'b1; end
      ST_PRE_T3:  if (dm_done) state_d = ST_DONE;
      ST_UPD_DV:  if (md_done) begin state_d = ST_UPD_VV; go_d = 1'b1; end
      ST_UPD_VV:  if (md_done) begin state_d = ST_UPD_HV; go_d = 1'b1; end
      ST_UPD_HV:  if (md_done) begin state_d = ST_UPD_DH; go_d = 1'b1; end
      ST_UPD_DH:  if (md_done) begin state_d = ST_UPD_HH; go_d = 1'b1; end
      ST_UPD_HH:  if (md_done) state_d = ST_DONE;
      ST_DONE:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      go_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
    end
  end

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= 16'd655;
      meas_var_q  <= 47'h1_0000_0000;
      proc_hh_q   <= '0;
      proc_hv_q   <= '0;
      proc_vv_q   <= '0;
      acc_off_q   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_TIME_STEP: time_step_q <= pwdata[15:0];
        REG_MEAS_VAR:  meas_var_q  <= pwdata[46:0];
        REG_PROC_HH:   proc_hh_q   <= pwdata[46:0];
        REG_PROC_HV:   proc_hv_q   <= pwdata[46:0];
        REG_PROC_VV:   proc_vv_q   <= pwdata[46:0];
        REG_ACC_OFF:   acc_off_q   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_TIME_STEP: prdata = {48'd0, time_step_q};
      REG_MEAS_VAR:  prdata = {17'd0, meas_var_q};
      REG_PROC_HH:   prdata = {17'd0, proc_hh_q};
      REG_PROC_HV:   prdata = {17'd0, proc_hv_q};
      REG_PROC_VV:   prdata = {17'd0, proc_vv_q};
      REG_ACC_OFF:   prdata = {32'd0, acc_off_q};
      default:       prdata = '0;
    endcase
  end

  // filter state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q   <= '0;
      velocity_q <= '0;
      cov_hh_q   <= HH_INIT;
      cov_hv_q   <= '0;
      cov_vv_q   <= VV_INIT;
      flag_q     <= 1'b0;
    end else begin
      if (accept) begin
        flag_q <= (mode_i == MODE_UPDATE) && (s_now == 48'd0);
        if (mode_i == MODE_RESTART) begin
          height_q   <= sample_value_i;
          velocity_q <= '0;
          cov_hh_q   <= HH_INIT;
          cov_hv_q   <= '0;
          cov_vv_q   <= VV_INIT;
        end
      end
      if (dm_done) begin
        if (state_q == ST_PRE_P2) begin
          height_q   <= sat32(ext32(height_q) + dh64);
          velocity_q <= sat32(ext32(velocity_q) + ext50(adt_q));
        end
        if (state_q == ST_PRE_T2)
          cov_hv_q <= clamp_cov(ext48(cov_hv_q) + ext50(dm_res)
                                + $signed({17'd0, proc_hv_q}), 1'b0);
        if (state_q == ST_PRE_T3) begin
          cov_hh_q <= clamp_cov(ext48(cov_hh_q) + (ext50(acc1_q) <<< 1) + ext50(dm_res)
                                + $signed({17'd0, proc_hh_q}), 1'b1);
          cov_vv_q <= clamp_cov(ext48(cov_vv_q) + $signed({17'd0, proc_vv_q}), 1'b1);
        end
      end
      if (md_done) begin
        unique case (state_q)
          ST_UPD_DV: velocity_q <= sat32(ext32(velocity_q) + md_m);
          ST_UPD_VV: cov_vv_q   <= clamp_cov(ext48(cov_vv_q) - md_m, 1'b1);
          ST_UPD_HV: cov_hv_q   <= clamp_cov(md_m, 1'b0);
          ST_UPD_DH: height_q   <= sat32(ext32(height_q) + md_m);
          ST_UPD_HH: cov_hh_q   <= clamp_cov(md_m, 1'b1);
          default: ;
        endcase
      end
    end
  end

  // per-item scratch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_value_i;
      y_q      <= y_now;
      s_q      <= s_now;
    end
    if (dm_done) begin
      if (state_q == ST_PRE_ADT) adt_q <= dm_res;
      if (state_q == ST_PRE_P1 || state_q == ST_PRE_T1) acc1_q <= dm_res;
      if (state_q == ST_PRE_T2) t2_q <= dm_res;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_h_q    <= height_q;
      out_v_q    <= velocity_q;
      out_var_q  <= cov_hh_q[46:0];
      out_flag_q <= flag_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign est_height_o      = out_h_q;
  assign est_velocity_o    = out_v_q;
  assign height_var_o      = out_var_q;
  assign zero_innovation_o = out_flag_q;

  a_hh_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cov_hh_q[47]) else $error("height variance went negative");

  a_vv_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cov_vv_q[47]) else $error("velocity variance went negative");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done state");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE) else $error("accepted beat not started");

  a_single_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dm_done && md_done)) else $error("both arithmetic units finished at once");

endmodule

FILE: tb/akf_checker.sv
// Checker for the altitude Kalman filter: tracks register writes, predicts each estimate
// and compares the result beats in order. Depends on akf_pkg.
module akf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] sample_value_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [31:0] est_height_o,
  input  logic [31:0] est_velocity_o,
  input  logic [46:0] height_var_o,
  input  logic        zero_innovation_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  import akf_pkg::*;

  typedef struct packed {
    logic [31:0] height;
    logic [31:0] velocity;
    logic [46:0] hvar;
    logic        skipped;
  } estimate_t;

  localparam logic signed [63:0] GRAVITY = ((64'sd981 <<< 16) + 64'sd50) / 64'sd100;
  localparam logic signed [63:0] HH_INIT = 64'sd1 <<< 31;
  localparam logic signed [63:0] VV_INIT = ((64'sd105 <<< 32) + 64'sd50) / 64'sd100;
  localparam logic [127:0] QCAP = 128'd1 << 62;

  estimate_t expected_estimates[$];

  logic [15:0] dt_q;
  logic [46:0] r_var, q_hh, q_hv, q_vv;
  logic [31:0] acc_bias;
  logic signed [63:0] h_st, v_st, p_hh, p_hv, p_vv;

  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x, input int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [63:0] clip(input logic signed [63:0] x,
                                              input logic signed [63:0] lo,
                                              input logic signed [63:0] hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // round(a*b/c) half up, capped at 2^62 (huge quotients collapse to the cap)
  function automatic logic signed [63:0] scaled_ratio(input logic signed [63:0] a,
                                                      input logic signed [63:0] b,
                                                      input logic [63:0] c);
    logic [127:0] ua, ub, prod, quo, rem;
    logic neg;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? 128'(-a) : 128'(a);
    ub = b < 0 ? 128'(-b) : 128'(b);
    prod = ua * ub;
    quo = prod / c;
    rem = prod % c;
    if (quo >= (128'd1 << 63)) quo = QCAP;
    else begin
      if (2 * rem >= c) quo = quo + 1;
      if (quo > QCAP) quo = QCAP;
    end
    return neg ? -$signed(quo[63:0]) : $signed(quo[63:0]);
  endfunction

  task automatic filter_step(input logic [1:0] md, input logic [31:0] smp,
                             output estimate_t e);
    logic signed [63:0] s, dt, a, adt, dh, t1, t2, t3, y, rv;
    logic [63:0] sv;
    s = ext32(smp);
    dt = 64'(dt_q);
    e.skipped = 1'b0;
    case (md)
      MODE_PREDICT: begin
        a = s - GRAVITY - ext32(acc_bias);
        adt = rnd_shr(a * dt, 16);
        dh = rnd_shr(v_st * dt, 16) + rnd_shr(adt * dt, 17);
        t1 = rnd_shr(p_hv * dt, 16);
        t2 = rnd_shr(p_vv * dt, 16);
        t3 = rnd_shr(t2 * dt, 16);
        h_st = clip(h_st + dh, S32_MIN, S32_MAX);
        v_st = clip(v_st + adt, S32_MIN, S32_MAX);
        p_hh = clip(p_hh + 2 * t1 + t3 + 64'(q_hh), 0, COV_MAX64);
        p_hv = clip(p_hv + t2 + 64'(q_hv), COV_MIN64, COV_MAX64);
        p_vv = clip(p_vv + 64'(q_vv), 0, COV_MAX64);
      end
      MODE_UPDATE: begin
        sv = 64'(p_hh) + 64'(r_var);
        if (sv == 0) e.skipped = 1'b1;
        else begin
          y = s - h_st;
          rv = 64'(r_var);
          dh = scaled_ratio(p_hh, y, sv);
          adt = scaled_ratio(p_hv, y, sv);
          t1 = scaled_ratio(p_hh, rv, sv);
          t2 = scaled_ratio(p_hv, rv, sv);
          t3 = p_vv - scaled_ratio(p_hv, p_hv, sv);
          h_st = clip(h_st + dh, S32_MIN, S32_MAX);
          v_st = clip(v_st + adt, S32_MIN, S32_MAX);
          p_hh = clip(t1, 0, COV_MAX64);
          p_hv = clip(t2, COV_MIN64, COV_MAX64);
          p_vv = clip(t3, 0, COV_MAX64);
        end
      end
      MODE_RESTART: begin
        h_st = s;
        v_st = 0;
        p_hh = HH_INIT;
        p_hv = 0;
        p_vv = VV_INIT;
      end
      default: ;
    endcase
    e.height = h_st[31:0];
    e.velocity = v_st[31:0];
    e.hvar = p_hh[46:0];
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t e, want;
    if (!rst_ni) begin
      dt_q <= 16'd655;
      r_var <= 47'h1_0000_0000;
      q_hh <= '0;
      q_hv <= '0;
      q_vv <= '0;
      acc_bias <= '0;
      h_st = 0;
      v_st = 0;
      p_hh = HH_INIT;
      p_hv = 0;
      p_vv = VV_INIT;
      expected_estimates.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_TIME_STEP: dt_q <= pwdata[15:0];
          REG_MEAS_VAR:  r_var <= pwdata[46:0];
          REG_PROC_HH:   q_hh <= pwdata[46:0];
          REG_PROC_HV:   q_hv <= pwdata[46:0];
          REG_PROC_VV:   q_vv <= pwdata[46:0];
          REG_ACC_OFF:   acc_bias <= pwdata[31:0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_estimates.size() == 0) report("unexpected beat", est_height_o, 0);
        else begin
          want = expected_estimates.pop_front();
          if (est_height_o !== want.height) report("height", est_height_o, want.height);
          if (est_velocity_o !== want.velocity)
            report("velocity", est_velocity_o, want.velocity);
          if (height_var_o !== want.hvar) report("height_var", height_var_o, want.hvar);
          if (zero_innovation_o !== want.skipped)
            report("zero_innovation", zero_innovation_o, want.skipped);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        filter_step(mode_i, sample_value_i, e);
        expected_estimates.push_back(e);
      end
      pending = expected_estimates.size();
    end
  end

endmodule

FILE: tb/tb_altitude_kalman_filter.sv
// Testbench top for altitude_kalman_filter: clock, reset, APB register writes,
// item stimulus and receiver stalls. Depends on akf_pkg, the RTL and akf_checker.
module tb_altitude_kalman_filter;
  import akf_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = MODE_RESTART;
  logic [31:0] sample_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] est_height_o, est_velocity_o;
  logic [46:0] height_var_o;
  logic        zero_innovation_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  int fail_count, pending;
  int burst_left = 0;
  bit long_hold_req = 1'b0;

  localparam logic [46:0] MAX47 = {47{1'b1}};

  always #5 clk_i = ~clk_i;

  altitude_kalman_filter dut (.*);

  akf_checker u_checker (.*);

  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic push_item(input logic [1:0] md, input logic [31:0] smp);
    in_valid_i <= 1'b1;
    mode_i <= md;
    sample_value_i <= smp;
    do @(posedge clk_i); while (in_stall_o);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [46:0] pick47(input int extreme_pct, input int shift_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < extreme_pct) return $urandom_range(0, 1) ? MAX47 : 47'd0;
    return 47'({$urandom, $urandom} >> (17 + $urandom_range(0, shift_max)));
  endfunction

  function automatic logic [31:0] pick_sample(input logic [1:0] md);
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: begin
        // acceleration near 1 g, or a height within a few hundred metres
        if (md == MODE_PREDICT) return 32'd642908 + 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
        return 32'($signed($urandom_range(0, 40_000_000)) - 20_000_000);
      end
    endcase
  endfunction

  // receiver: its own stall pattern, plus one long hold-off to back the block up
  initial begin
    int run;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (6000) @(posedge clk_i);
      end
      run = $urandom_range(1, 40);
      case ($urandom_range(0, 3))
        0: begin
          out_stall_i <= 1'b0;
          repeat (run) @(posedge clk_i);
        end
        1: begin
          out_stall_i <= 1'b1;
          repeat (run) @(posedge clk_i);
        end
        default: repeat (run) begin
          out_stall_i <= $urandom_range(0, 2) == 0;
          @(posedge clk_i);
        end
      endcase
    end
  end

  initial begin
    logic [1:0] md;
    int r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes and every mode on the reset settings
    push_item(MODE_RESTART, 32'h7FFF_FFFF);
    push_item(MODE_PREDICT, 32'h7FFF_FFFF);
    push_item(MODE_PREDICT, 32'h8000_0000);
    push_item(MODE_UPDATE, 32'h8000_0000);
    push_item(MODE_UPDATE, 32'h7FFF_FFFF);
    push_item(MODE_RESTART, 32'h8000_0000);
    push_item(MODE_PREDICT, 32'h0);
    push_item(MODE_SPARE, 32'hFFFF_FFFF);
    push_item(MODE_UPDATE, 32'h0);
    push_item(MODE_RESTART, 32'h0);
    wait_drained();

    // zero measurement noise: first update clears cov_hh, the next has zero innovation
    write_reg(REG_MEAS_VAR, 64'd0);
    push_item(MODE_UPDATE, 32'h0001_0000);
    push_item(MODE_UPDATE, 32'h0002_0000);
    push_item(MODE_UPDATE, 32'hFFFF_0000);
    wait_drained();

    // large process noise and step: covariances and velocity saturate
    write_reg(REG_TIME_STEP, 64'hFFFF);
    write_reg(REG_PROC_HH, 64'(MAX47));
    write_reg(REG_PROC_HV, 64'(MAX47));
    write_reg(REG_PROC_VV, 64'(MAX47));
    write_reg(REG_ACC_OFF, 64'h8000_0000);
    repeat (4) push_item(MODE_PREDICT, 32'h7FFF_FFFF);
    wait_drained();
    write_reg(REG_MEAS_VAR, 64'(MAX47));
    push_item(MODE_UPDATE, 32'h8000_0000);
    push_item(MODE_UPDATE, 32'h7FFF_FFFF);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_TIME_STEP, 64'd1);
          write_reg(REG_ACC_OFF, 64'h7FFF_FFFF);
          write_reg(REG_MEAS_VAR, 64'h1_0000_0000);
        end
        1: begin
          write_reg(REG_TIME_STEP, 64'hFFFF);
          write_reg(REG_ACC_OFF, 64'h8000_0000);
          write_reg(REG_MEAS_VAR, 64'(MAX47));
        end
        default: begin
          write_reg(REG_TIME_STEP, $urandom_range(0, 3) == 0 ? 64'd655 : 64'($urandom_range(1, 65535)));
          write_reg(REG_ACC_OFF, 64'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 200000)));
          write_reg(REG_MEAS_VAR, 64'(pick47(15, 14)));
        end
      endcase
      write_reg(REG_PROC_HH, 64'(pick47(20, 14)));
      write_reg(REG_PROC_HV, 64'(pick47(20, 14)));
      write_reg(REG_PROC_VV, 64'(pick47(20, 14)));
      if (phase == 2) long_hold_req = 1'b1;
      repeat (144) begin
        r = $urandom_range(0, 99);
        md = r < 48 ? MODE_PREDICT : r < 85 ? MODE_UPDATE : r < 95 ? MODE_RESTART : MODE_SPARE;
        push_item(md, pick_sample(md));
      end
      wait_drained();
    end

    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

FILE: files.f
hdl/akf_pkg.sv
hdl/akf_dtmul.sv
hdl/akf_muldiv.sv
hdl/altitude_kalman_filter.sv
tb/akf_checker.sv
tb/tb_altitude_kalman_filter.sv
